/* hdl/stream_word_replace_macros.svh */
// Assertion macros shared by the word replacer RTL.
// Each macro checks one implication on the rising edge of aclk and is
// disabled while aresetn is low.
`ifndef STREAM_WORD_REPLACE_MACROS_SVH
`define STREAM_WORD_REPLACE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define SWR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define SWR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SWR_ASSERT_IMP(lbl, ante, cons, msg)
`define SWR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/swr_pkg.sv */
`timescale 1ns / 1ps

package swr_pkg;

    // Fixed widths of the register fields and datapath counters.
    localparam int WORD_W     = 64;
    localparam int WORD_BYTES = 8;
    localparam int COUNT_W    = 4;
    localparam int IDX_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int STEP_W     = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_WORD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_WORD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LENGTH = 2'd3;

    // Microprogram addresses.
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_IN    = 4'd0;
    localparam step_t STEP_CHK   = 4'd1;
    localparam step_t STEP_FULL  = 4'd2;
    localparam step_t STEP_SHIFT = 4'd3;
    localparam step_t STEP_RZ    = 4'd4;
    localparam step_t STEP_REPL  = 4'd5;
    localparam step_t STEP_FLCHK = 4'd6;
    localparam step_t STEP_FLUSH = 4'd7;
    localparam step_t STEP_DONE  = 4'd8;

    // Source of an emitted byte.
    typedef enum logic {
        SRC_HOLD = 1'b0,
        SRC_REPL = 1'b1
    } src_t;

    // Branch conditions tested by the sequencer.
    typedef enum logic [2:0] {
        COND_ALWAYS    = 3'd0,
        COND_MISMATCH  = 3'd1,
        COND_FULL      = 3'd2,
        COND_REPL_ZERO = 3'd3,
        COND_REPL_LAST = 3'd4,
        COND_FLUSH     = 3'd5,
        COND_N_ONE     = 3'd6
    } cond_t;

    // One control word of the microprogram.
    typedef struct packed {
        logic  accept;
        logic  emit;
        src_t  src;
        logic  shift;
        logic  clr_n;
        logic  inc_i;
        logic  finish;
        cond_t cond;
        step_t tgt_true;
        step_t tgt_false;
    } ctrl_t;

    // Status flags returned by the datapath.
    typedef struct packed {
        logic stall;
        logic mismatch;
        logic full;
        logic repl_zero;
        logic repl_last;
        logic flush;
        logic n_one;
    } stat_t;

endpackage

/* hdl/swr_seq.sv */
`timescale 1ns / 1ps

module swr_seq import swr_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  stat_t stat,
    output ctrl_t ctrl
);

    step_t step_reg;
    step_t step_next;
    logic  cond_true;

    // Microprogram store: one control word per step.
    function automatic ctrl_t prog_word(input step_t s);
        ctrl_t w;
        w           = '0;
        w.src       = SRC_HOLD;
        w.cond      = COND_ALWAYS;
        w.tgt_true  = STEP_IN;
        w.tgt_false = STEP_IN;
        case (s)
            STEP_IN: begin
                w.accept   = 1'b1;
                w.tgt_true = STEP_CHK;
            end
            STEP_CHK: begin
                w.cond      = COND_MISMATCH;
                w.tgt_true  = STEP_SHIFT;
                w.tgt_false = STEP_FULL;
            end
            STEP_FULL: begin
                w.cond      = COND_FULL;
                w.tgt_true  = STEP_RZ;
                w.tgt_false = STEP_FLCHK;
            end
            STEP_SHIFT: begin
                w.emit      = 1'b1;
                w.shift     = 1'b1;
                w.cond      = COND_N_ONE;
                w.tgt_true  = STEP_DONE;
                w.tgt_false = STEP_CHK;
            end
            STEP_RZ: begin
                w.clr_n     = 1'b1;
                w.cond      = COND_REPL_ZERO;
                w.tgt_true  = STEP_DONE;
                w.tgt_false = STEP_REPL;
            end
            STEP_REPL: begin
                w.emit      = 1'b1;
                w.src       = SRC_REPL;
                w.inc_i     = 1'b1;
                w.cond      = COND_REPL_LAST;
                w.tgt_true  = STEP_DONE;
                w.tgt_false = STEP_REPL;
            end
            STEP_FLCHK: begin
                w.cond      = COND_FLUSH;
                w.tgt_true  = STEP_FLUSH;
                w.tgt_false = STEP_DONE;
            end
            STEP_FLUSH: begin
                w.emit      = 1'b1;
                w.shift     = 1'b1;
                w.cond      = COND_N_ONE;
                w.tgt_true  = STEP_DONE;
                w.tgt_false = STEP_FLUSH;
            end
            STEP_DONE: begin
                w.finish   = 1'b1;
                w.tgt_true = STEP_IN;
            end
            default: begin
                w.tgt_true = STEP_IN;
            end
        endcase
        return w;
    endfunction

    assign ctrl = prog_word(step_reg);

    // Branch condition select.
    always_comb begin
        case (ctrl.cond)
            COND_ALWAYS:    cond_true = 1'b1;
            COND_MISMATCH:  cond_true = stat.mismatch;
            COND_FULL:      cond_true = stat.full;
            COND_REPL_ZERO: cond_true = stat.repl_zero;
            COND_REPL_LAST: cond_true = stat.repl_last;
            COND_FLUSH:     cond_true = stat.flush;
            COND_N_ONE:     cond_true = stat.n_one;
            default:        cond_true = 1'b1;
        endcase
    end

    // Step counter advances unless the datapath stalls.
    always_comb begin
        step_next = step_reg;
        if (!stat.stall) begin
            step_next = cond_true ? ctrl.tgt_true : ctrl.tgt_false;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IN;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

/* hdl/swr_dp.sv */
`timescale 1ns / 1ps
`include "stream_word_replace_macros.svh"

module swr_dp import swr_pkg::*; #(
    parameter int MAX_WORD = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctrl_t              ctrl,
    output stat_t              stat,
    input  logic [WORD_W-1:0]  srch_word,
    input  logic [COUNT_W-1:0] srch_len,
    input  logic [WORD_W-1:0]  repl_word,
    input  logic [COUNT_W-1:0] repl_len,
    input  logic               held_clr,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_char,
    input  logic               s_line_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_char,
    output logic               m_run_last
);

    logic [7:0]         hold_reg [MAX_WORD];
    logic [7:0]         srch_b [WORD_BYTES];
    logic [7:0]         repl_b [WORD_BYTES];
    logic [COUNT_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic               flush_reg;
    logic               pend_valid_reg, pend_valid_next;
    logic [7:0]         pend_char_reg, pend_char_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_char_reg, m_char_next;
    logic               m_last_reg, m_last_next;
    logic               prefix;
    logic               out_free;
    logic               push_need;
    logic               stall;
    logic               go;
    logic [7:0]         emit_byte;

    // Split the packed words into bytes.
    always_comb begin
        for (int j = 0; j < WORD_BYTES; j++) begin
            srch_b[j] = srch_word[j*8 +: 8];
            repl_b[j] = repl_word[j*8 +: 8];
        end
    end

    // Held bytes are a prefix of the search word when every valid entry matches.
    always_comb begin
        prefix = 1'b1;
        for (int j = 0; j < MAX_WORD; j++) begin
            if ((COUNT_W'(j) < n_reg) && (hold_reg[j] != srch_b[j])) begin
                prefix = 1'b0;
            end
        end
    end

    // Handshake and stall decisions for the current step.
    assign out_free  = !m_valid_reg || m_ready;
    assign push_need = (ctrl.emit || ctrl.finish) && pend_valid_reg;
    assign stall     = (ctrl.accept && !s_valid) || (push_need && !out_free);
    assign go        = !stall;
    assign emit_byte = (ctrl.src == SRC_REPL) ? repl_b[i_reg] : hold_reg[0];

    assign stat.stall     = stall;
    assign stat.mismatch  = !prefix;
    assign stat.full      = prefix && (n_reg == srch_len);
    assign stat.repl_zero = (repl_len == '0);
    assign stat.repl_last = ((COUNT_W'(i_reg) + COUNT_W'(1)) == repl_len);
    assign stat.flush     = flush_reg && (n_reg != '0);
    assign stat.n_one     = (n_reg == COUNT_W'(1));

    // Held byte count and replacement byte index.
    always_comb begin
        n_next = n_reg;
        i_next = i_reg;
        if (held_clr) begin
            n_next = '0;
        end else if (go) begin
            if (ctrl.accept) begin
                n_next = n_reg + COUNT_W'(1);
            end else if (ctrl.shift) begin
                n_next = n_reg - COUNT_W'(1);
            end else if (ctrl.clr_n) begin
                n_next = '0;
            end
        end
        if (go && ctrl.inc_i) begin
            i_next = i_reg + IDX_W'(1);
        end else if (go && ctrl.finish) begin
            i_next = '0;
        end
    end

    // One byte waits in the pending slot so the last one of a request can be marked.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_char_next     = m_char_reg;
        m_last_next     = m_last_reg;
        if (go && push_need) begin
            m_valid_next = 1'b1;
            m_char_next  = pend_char_reg;
            m_last_next  = ctrl.finish;
        end
        if (go && ctrl.emit) begin
            pend_valid_next = 1'b1;
            pend_char_next  = emit_byte;
        end else if (go && ctrl.finish) begin
            pend_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg          <= '0;
            i_reg          <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            n_reg          <= n_next;
            i_reg          <= i_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers and the held byte buffer.
    always_ff @(posedge aclk) begin
        pend_char_reg <= pend_char_next;
        m_char_reg    <= m_char_next;
        m_last_reg    <= m_last_next;
        if (go && ctrl.accept) begin
            flush_reg <= s_line_end;
            for (int j = 0; j < MAX_WORD; j++) begin
                if (COUNT_W'(j) == n_reg) begin
                    hold_reg[j] <= s_in_char;
                end
            end
        end else if (go && ctrl.shift) begin
            for (int j = 0; j < MAX_WORD - 1; j++) begin
                hold_reg[j] <= hold_reg[j+1];
            end
        end
    end

    assign s_ready    = ctrl.accept;
    assign m_valid    = m_valid_reg;
    assign m_out_char = m_char_reg;
    assign m_run_last = m_last_reg;

    `SWR_ASSERT_IMP(a_held_below_len, go && ctrl.accept, n_reg < srch_len, "held count not below search length")
    `SWR_ASSERT_IMP(a_no_pend_at_accept, ctrl.accept, !pend_valid_reg, "byte pending at new request")
    `SWR_ASSERT_IMP(a_repl_index, ctrl.emit && (ctrl.src == SRC_REPL), COUNT_W'(i_reg) < repl_len, "replacement index past length")
    `SWR_ASSERT_NXT(a_last_marked, go && ctrl.finish && pend_valid_reg, m_valid_reg && m_last_reg, "final byte not marked last")

endmodule

/* hdl/stream_word_replace.sv */
`timescale 1ns / 1ps

// Streaming find-and-replace of one search word within text lines.
// Input channel (s_): one byte per request, s_line_end marks the last byte of
// a line. Output channel (m_): rewritten bytes; m_run_last marks the last byte
// caused by an input request. A request that only extends a partial match
// causes no output byte at all.
// Configuration: cfg_we writes cfg_data to register cfg_index.
// Write only while idle; a write to the search word or length drops held bytes.
// Timing: a microprogram sequencer steps through one request at a time. A
// request passes the accept and mismatch check steps. On a mismatch the shift
// step releases the oldest held byte and the check repeats; a release that
// empties the buffer skips the match and flush checks. A full match clears
// the held bytes and the replace step emits the replacement bytes; else the
// flush step releases held bytes at line end. Output bytes wait in the pending
// slot before the output register. A stall on m_ready holds the sequencer once
// the output register and the one-byte pending slot are both full.
// Reset: synchronous, active low; control and configuration registers return
// to their reset values and no bytes are held.
module stream_word_replace import swr_pkg::*; #(
    parameter int MAX_WORD = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_in_char,
    input  logic                 s_line_end,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_char,
    output logic                 m_run_last,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    logic [WORD_W-1:0]  search_word_reg;
    logic [COUNT_W-1:0] search_len_reg;
    logic [WORD_W-1:0]  replace_word_reg;
    logic [COUNT_W-1:0] replace_len_reg;
    logic [COUNT_W-1:0] srch_len_eff;
    logic [COUNT_W-1:0] repl_len_eff;
    logic               held_clr;
    ctrl_t              ctrl;
    stat_t              stat;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            search_word_reg  <= '0;
            search_len_reg   <= COUNT_W'(1);
            replace_word_reg <= '0;
            replace_len_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SEARCH_WORD:    search_word_reg  <= cfg_data;
                REG_SEARCH_LENGTH:  search_len_reg   <= cfg_data[COUNT_W-1:0];
                REG_REPLACE_WORD:   replace_word_reg <= cfg_data;
                REG_REPLACE_LENGTH: replace_len_reg  <= cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A new search word invalidates any partial match.
    assign held_clr = cfg_we &&
                      ((cfg_index == REG_SEARCH_WORD) || (cfg_index == REG_SEARCH_LENGTH));

    // Clamp the lengths: search length at least one, both at most MAX_WORD.
    always_comb begin
        if (search_len_reg == '0) begin
            srch_len_eff = COUNT_W'(1);
        end else if (search_len_reg > COUNT_W'(MAX_WORD)) begin
            srch_len_eff = COUNT_W'(MAX_WORD);
        end else begin
            srch_len_eff = search_len_reg;
        end
        if (replace_len_reg > COUNT_W'(MAX_WORD)) begin
            repl_len_eff = COUNT_W'(MAX_WORD);
        end else begin
            repl_len_eff = replace_len_reg;
        end
    end

    swr_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    swr_dp #(
        .MAX_WORD (MAX_WORD)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .stat       (stat),
        .srch_word  (search_word_reg),
        .srch_len   (srch_len_eff),
        .repl_word  (replace_word_reg),
        .repl_len   (repl_len_eff),
        .held_clr   (held_clr),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_char  (s_in_char),
        .s_line_end (s_line_end),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_run_last (m_run_last)
    );

endmodule

/* verif/stream_word_replace_checker.sv */
`timescale 1ns / 1ps

// Watches both channels and the register port of the word replacer, rewrites
// every accepted request with its own copy of the match state, and compares
// each output byte against the oldest predicted byte.
module stream_word_replace_checker import swr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [7:0]           s_in_char,
    input  logic                 s_line_end,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [7:0]           m_out_char,
    input  logic                 m_run_last,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output int                   mismatch_count,
    output int                   pending_count
);

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } text_byte_t;

    // Predicted bytes of the rewritten text, oldest first.
    text_byte_t rewritten_q [$];

    // Shadow copy of the registers and of the partial match.
    logic [WORD_W-1:0] search_word;
    logic [3:0]        search_len_reg;
    logic [WORD_W-1:0] replace_word;
    logic [3:0]        replace_len_reg;
    logic [7:0]        held [0:WORD_BYTES-1];
    int unsigned       held_n;

    // Rewrite one request: release bytes that can no longer start a match,
    // substitute a completed match, and flush what is left at line end.
    task automatic rewrite_request(input logic [7:0] in_char, input logic flush);
        logic [7:0]  win [0:WORD_BYTES];
        int unsigned span, rlen, n, i, first;
        logic        prefix, partial;
        text_byte_t  tail;
        span = search_len_reg;
        if (span == 0) span = 1;
        if (span > WORD_BYTES) span = WORD_BYTES;
        rlen = replace_len_reg;
        if (rlen > WORD_BYTES) rlen = WORD_BYTES;
        first = rewritten_q.size();

        n = (held_n > span - 1) ? span - 1 : held_n;
        for (i = 0; i < n; i++) win[i] = held[i];
        win[n] = in_char;
        n++;

        partial = 1'b0;
        while (n > 0 && !partial) begin
            prefix = 1'b1;
            for (i = 0; i < n; i++) begin
                if (win[i] != search_word[8*i +: 8]) prefix = 1'b0;
            end
            if (prefix && n == span) begin
                for (i = 0; i < rlen; i++) rewritten_q.push_back({replace_word[8*i +: 8], 1'b0});
                n = 0;
            end else if (prefix) begin
                partial = 1'b1;
            end else begin
                // Oldest byte cannot start a match; release it and recheck the rest.
                rewritten_q.push_back({win[0], 1'b0});
                for (i = 1; i < n; i++) win[i-1] = win[i];
                n--;
            end
        end

        if (flush) begin
            for (i = 0; i < n; i++) rewritten_q.push_back({win[i], 1'b0});
            n = 0;
        end

        for (i = 0; i < n; i++) held[i] = win[i];
        held_n = n;

        // The final byte caused by this request carries the run marker.
        if (rewritten_q.size() > first) begin
            tail = rewritten_q.pop_back();
            tail.run_last = 1'b1;
            rewritten_q.push_back(tail);
        end
    endtask

    // Results are checked before a request at the same edge is predicted,
    // since a result always belongs to an earlier request.
    always @(posedge aclk) begin : monitor
        text_byte_t head;
        if (!aresetn) begin
            search_word     = '0;
            search_len_reg  = 4'd1;
            replace_word    = '0;
            replace_len_reg = 4'd0;
            held_n          = 0;
            mismatch_count  = 0;
            rewritten_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (rewritten_q.size() == 0) begin
                    $error("out_char: expected nothing, actual %02h", m_out_char);
                    mismatch_count++;
                end else begin
                    head = rewritten_q.pop_front();
                    if (m_out_char !== head.out_char) begin
                        $error("out_char: expected %02h, actual %02h",
                               head.out_char, m_out_char);
                        mismatch_count++;
                    end
                    if (m_run_last !== head.run_last) begin
                        $error("run_last: expected %0b, actual %0b",
                               head.run_last, m_run_last);
                        mismatch_count++;
                    end
                end
            end

            // A write to either search register drops the partial match.
            if (cfg_we) begin
                case (cfg_index)
                    REG_SEARCH_WORD: begin
                        search_word = cfg_data;
                        held_n = 0;
                    end
                    REG_SEARCH_LENGTH: begin
                        search_len_reg = cfg_data[3:0];
                        held_n = 0;
                    end
                    REG_REPLACE_WORD: begin
                        replace_word = cfg_data;
                    end
                    REG_REPLACE_LENGTH: begin
                        replace_len_reg = cfg_data[3:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (s_valid && s_ready) rewrite_request(s_in_char, s_line_end);
        end
        pending_count = rewritten_q.size();
    end

endmodule

/* verif/tb_stream_word_replace.sv */
`timescale 1ns / 1ps

module tb_stream_word_replace;

    import swr_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_in_char;
    logic                 s_line_end;
    logic                 m_valid;
    logic                 m_ready;
    logic [7:0]           m_out_char;
    logic                 m_run_last;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    int mismatch_count;
    int pending_count;

    // Traffic shaping shared by the sender and the receiver.
    bit idle_on      = 1'b1;
    bit hold_request = 1'b0;
    bit hold_served  = 1'b0;

    // Current search word as the stimulus sees it, used to build near matches.
    logic [WORD_W-1:0] search_copy;
    int unsigned       search_span;

    stream_word_replace uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_char  (s_in_char),
        .s_line_end (s_line_end),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_run_last (m_run_last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    stream_word_replace_checker checker_inst (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_char      (s_in_char),
        .s_line_end     (s_line_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_char     (m_out_char),
        .m_run_last     (m_run_last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random back-pressure, plus one long hold-off that lets the
    // block fill up and stall its input.
    initial begin : result_sink
        int unsigned held_cycles;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                m_ready <= 1'b0;
                for (held_cycles = 0; held_cycles < 300; held_cycles++) @(negedge aclk);
            end else if (idle_on) begin
                m_ready <= ($urandom_range(99) >= 9);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Hard limit on the run.
    initial begin
        #3_000_000;
        $display("stream_word_replace verification failed");
        $finish;
    end

    // Register write; the enable drops for one cycle between writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Program all four registers. Length writes carry random upper bits,
    // which the block must ignore.
    task automatic load_setting(input logic [WORD_W-1:0] sw, input logic [3:0] slen_raw,
                                input logic [WORD_W-1:0] rw, input logic [3:0] rlen_raw);
        logic [WORD_W-1:0] noise;
        noise = {$urandom, $urandom};
        write_reg(REG_SEARCH_WORD, sw);
        write_reg(REG_SEARCH_LENGTH, {noise[WORD_W-1:4], slen_raw});
        write_reg(REG_REPLACE_WORD, rw);
        noise = {$urandom, $urandom};
        write_reg(REG_REPLACE_LENGTH, {noise[WORD_W-1:4], rlen_raw});
        search_copy = sw;
        search_span = (slen_raw == 0) ? 1 : ((slen_raw > WORD_BYTES) ? WORD_BYTES : slen_raw);
    endtask

    // Offer one request and wait for it to be taken. Valid stays high on
    // return so that back-to-back requests are offered without a gap.
    task automatic send_request(input logic [7:0] in_char, input logic line_end);
        if (idle_on && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_in_char  <= in_char;
        s_line_end <= line_end;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drain the block: all predicted bytes out, then time for a request that
    // produces nothing to finish its pass through the sequencer.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (48) @(negedge aclk);
    endtask

    // Text built mostly from the search word: whole words, words with one
    // byte spoiled, loose bytes of the word, and some arbitrary bytes.
    task automatic send_random(input int unsigned count);
        int unsigned sent, pick, i, spoil, pos;
        logic [7:0]  c;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                spoil = ($urandom_range(3) == 0) ? $urandom_range(search_span - 1) : WORD_BYTES;
                for (i = 0; i < search_span; i++) begin
                    c = (i == spoil) ? 8'($urandom) : search_copy[8*i +: 8];
                    send_request(c, $urandom_range(11) == 0);
                    sent++;
                end
            end else if (pick < 85) begin
                pos = $urandom_range(search_span - 1);
                send_request(search_copy[8*pos +: 8], $urandom_range(11) == 0);
                sent++;
            end else begin
                send_request(8'($urandom), $urandom_range(11) == 0);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        int unsigned       phase, i;
        logic [WORD_W-1:0] sw;
        logic [3:0]        slen_raw, rlen_raw;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_in_char  = 8'h00;
        s_line_end = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_SEARCH_WORD;
        cfg_data   = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Search "abc", replace with "XY": a match, a fallback that releases
        // held bytes one by one, and a partial match flushed at line end.
        load_setting(64'h5A5A_A5A5_0063_6261, 4'd3, 64'hC3C3_0000_0000_5958, 4'd2);
        send_request("a", 1'b0);
        send_request("a", 1'b0);
        send_request("b", 1'b0);
        send_request("c", 1'b0);
        send_request("a", 1'b0);
        send_request("b", 1'b0);
        send_request("d", 1'b0);
        send_request("a", 1'b0);
        send_request("b", 1'b1);
        // Leave a byte held; the next search write must discard it.
        send_request("a", 1'b0);
        settle();

        // One-byte search of 0xFF; oversized replace length saturates to eight zero bytes.
        load_setting(64'h0000_0000_0000_00FF, 4'd1, 64'h0000_0000_0000_0000, 4'd15);
        send_request(8'hFF, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b1);
        settle();

        // Zero search length acts as one; zero replace length deletes matches,
        // so the line ends on a request with no output.
        load_setting(64'hFFFF_FFFF_FFFF_FF00, 4'd0, 64'h1234_5678_9ABC_DEF0, 4'd0);
        send_request(8'h00, 1'b0);
        send_request(8'h41, 1'b0);
        send_request(8'h00, 1'b1);
        settle();

        // Oversized search length saturates to eight: "aaaaaaab". Seven bytes
        // held, a fallback by one, then a full match with an eight-byte replacement.
        load_setting(64'h6261_6161_6161_6161, 4'd12, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        for (i = 0; i < 8; i++) send_request("a", 1'b0);
        send_request("b", 1'b0);
        settle();

        // Random text under a series of settings. Even phases use a two-letter
        // alphabet so that self-overlapping words force deep fallbacks.
        for (phase = 0; phase < 6; phase++) begin
            sw = {$urandom, $urandom};
            if (phase % 2 == 0) begin
                for (i = 0; i < WORD_BYTES; i++) sw[8*i +: 8] = 8'h61 + 8'($urandom_range(1));
            end
            case (phase)
                0: slen_raw = 4'd1;
                1: slen_raw = 4'd8;
                2: slen_raw = 4'd15;
                default: slen_raw = 4'($urandom_range(15));
            endcase
            case (phase)
                0: rlen_raw = 4'd0;
                1: rlen_raw = 4'd8;
                default: rlen_raw = 4'($urandom_range(15));
            endcase
            load_setting(sw, slen_raw, {$urandom, $urandom}, rlen_raw);
            idle_on = (phase != 3);
            if (phase == 4) hold_request = 1'b1;
            send_random(50);
            settle();
        end

        if (mismatch_count == 0) begin
            $display("stream_word_replace verification clean");
        end else begin
            $display("stream_word_replace verification failed");
        end
        $finish;
    end

endmodule
